FILE: hdl/uart_idle_timeout_frame_receiver_defines.svh
// assertion macros for the idle-timeout frame receiver
// used by the top level only, no other dependencies
`ifndef UART_IDLE_TIMEOUT_FRAME_RECEIVER_DEFINES_SVH
`define UART_IDLE_TIMEOUT_FRAME_RECEIVER_DEFINES_SVH

// same-cycle implication
`define UITF_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define UITF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/uitf_pkg.sv
// shared types and constants of the idle-timeout frame receiver
// no dependencies
package uitf_pkg;

   localparam int BUF_DEPTH_DEF = 512;
   localparam int DATA_W        = 8;
   localparam int LEN_W         = 9;
   localparam int IDX_W         = 9;
   localparam int COUNT_W       = 16;
   localparam int QUEUE_LOG2    = 2;
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 32;
   localparam logic [COUNT_W-1:0] TIMEOUT_RESET = 16'd100;

   typedef enum logic [2:0] {
      REQ_BYTE  = 3'd0,
      REQ_TICK  = 3'd1,
      REQ_POLL  = 3'd2,
      REQ_READ  = 3'd3,
      REQ_CLEAR = 3'd4
   } req_code_type;

   typedef enum logic {
      REG_IDLE_TIMEOUT = 1'b0
   } reg_index_type;

   typedef struct packed {
      logic             frame_done;
      logic [LEN_W-1:0] frame_length;
      logic             timer_active;
   } meta_type;

   typedef struct packed {
      logic done_pending;
      logic running;
   } front_status_type;

endpackage

FILE: hdl/uitf_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module uitf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: hdl/uitf_fifo.sv
// small register-based fifo, power-of-two depth
// no dependencies
module uitf_fifo #(
   parameter int WIDTH      = 8,
   parameter int DEPTH_LOG2 = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic [WIDTH-1:0]      push_data,
   input  logic                  pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  empty,
   output logic                  full,
   output logic [DEPTH_LOG2:0]   count
);

   localparam int DEPTH = 1 << DEPTH_LOG2;

   logic [WIDTH-1:0]      mem_ff [DEPTH];
   logic [DEPTH_LOG2-1:0] wr_ptr_ff, wr_ptr_in;
   logic [DEPTH_LOG2-1:0] rd_ptr_ff, rd_ptr_in;
   logic [DEPTH_LOG2:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = mem_ff[rd_ptr_ff];
   assign empty    = (count_ff == '0);
   assign full     = (count_ff == (DEPTH_LOG2 + 1)'(DEPTH));
   assign count    = count_ff;

endmodule

FILE: hdl/uitf_front.sv
// front end: decodes each transaction, keeps index, counter and flags
// depends on uitf_pkg
module uitf_front #(
   parameter int BUF_DEPTH = uitf_pkg::BUF_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept,
   input  logic [2:0]                      req_type,
   input  logic [uitf_pkg::DATA_W-1:0]     rx_data,
   input  logic [uitf_pkg::IDX_W-1:0]      read_index,
   input  logic [uitf_pkg::COUNT_W-1:0]    timeout,
   output logic [2+$clog2(BUF_DEPTH)+uitf_pkg::DATA_W+$bits(uitf_pkg::meta_type)-1:0] op_data,
   output uitf_pkg::front_status_type      status
);

   localparam int AW = $clog2(BUF_DEPTH);
   localparam int LW = uitf_pkg::LEN_W;
   localparam logic [AW-1:0] LAST = AW'(BUF_DEPTH - 1);

   logic [AW-1:0]                  widx_ff, widx_in;
   logic [LW-1:0]                  len_ff, len_in;
   logic                           done_ff, done_in;
   logic                           run_ff, run_in;
   logic [uitf_pkg::COUNT_W-1:0]   cnt_ff, cnt_in;

   logic [uitf_pkg::COUNT_W-1:0]   cnt_next;
   logic [AW+LW-1:0]               widx_pad;
   logic [AW+uitf_pkg::IDX_W-1:0]  ridx_pad;
   logic                           op_we, op_re, done_out;
   logic [AW-1:0]                  op_addr;
   logic [uitf_pkg::DATA_W-1:0]    op_wdata;
   uitf_pkg::meta_type             meta;

   always_comb begin
      widx_in  = widx_ff;
      len_in   = len_ff;
      done_in  = done_ff;
      run_in   = run_ff;
      cnt_in   = cnt_ff;
      op_we    = 1'b0;
      op_re    = 1'b0;
      op_addr  = widx_ff;
      op_wdata = '0;
      done_out = 1'b0;
      cnt_next = cnt_ff + 1'b1;
      widx_pad = {{LW{1'b0}}, widx_ff};
      ridx_pad = {{AW{1'b0}}, read_index};
      case (uitf_pkg::req_code_type'(req_type))
         uitf_pkg::REQ_BYTE: begin
            op_we    = 1'b1;
            op_wdata = rx_data;
            if (widx_ff != LAST) begin
               widx_in = widx_ff + 1'b1;
            end
            cnt_in = '0;
            run_in = 1'b1;
         end
         uitf_pkg::REQ_TICK: begin
            if (run_ff) begin
               cnt_in = cnt_next;
               if (cnt_next >= timeout || cnt_next == '0) begin
                  op_we   = 1'b1;
                  len_in  = widx_pad[LW-1:0];
                  widx_in = '0;
                  done_in = 1'b1;
                  run_in  = 1'b0;
                  cnt_in  = '0;
               end
            end
         end
         uitf_pkg::REQ_POLL: begin
            done_out = done_ff;
            done_in  = 1'b0;
         end
         uitf_pkg::REQ_READ: begin
            op_addr = ridx_pad[AW-1:0];
            op_re   = (32'(read_index) < 32'(BUF_DEPTH));
         end
         uitf_pkg::REQ_CLEAR: begin
            op_we   = 1'b1;
            op_addr = '0;
         end
         default: begin
         end
      endcase
      meta.frame_done   = done_out;
      meta.frame_length = len_in;
      meta.timer_active = run_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         widx_ff <= '0;
         len_ff  <= '0;
         done_ff <= 1'b0;
         run_ff  <= 1'b0;
         cnt_ff  <= '0;
      end else if (accept) begin
         widx_ff <= widx_in;
         len_ff  <= len_in;
         done_ff <= done_in;
         run_ff  <= run_in;
         cnt_ff  <= cnt_in;
      end
   end

   assign op_data             = {op_we, op_re, op_addr, op_wdata, meta};
   assign status.done_pending = done_ff;
   assign status.running      = run_ff;

endmodule

FILE: hdl/uitf_back.sv
// back end: buffer ram, post-reset clear sweep, read stage and result fifo
// depends on uitf_pkg, uitf_ram, uitf_fifo
module uitf_back #(
   parameter int BUF_DEPTH = uitf_pkg::BUF_DEPTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        op_empty,
   input  logic [2+$clog2(BUF_DEPTH)+uitf_pkg::DATA_W+$bits(uitf_pkg::meta_type)-1:0] op_data,
   output logic                        op_pop,
   output logic                        clearing,
   input  logic                        rsp_pop,
   output logic                        rsp_empty,
   output logic                        rsp_frame_done,
   output logic [uitf_pkg::LEN_W-1:0]  rsp_frame_length,
   output logic [uitf_pkg::DATA_W-1:0] rsp_read_byte,
   output logic                        rsp_timer_active
);

   localparam int AW = $clog2(BUF_DEPTH);
   localparam int DW = uitf_pkg::DATA_W;
   localparam int QL = uitf_pkg::QUEUE_LOG2;
   localparam int RW = $bits(uitf_pkg::meta_type) + DW;
   localparam logic [AW-1:0] LAST = AW'(BUF_DEPTH - 1);

   logic                 op_we, op_re;
   logic [AW-1:0]        op_addr;
   logic [DW-1:0]        op_wdata;
   uitf_pkg::meta_type   op_meta;

   logic                 clr_busy_ff, clr_busy_in;
   logic [AW-1:0]        clr_addr_ff, clr_addr_in;
   logic                 s1_valid_ff;
   logic                 s1_re_ff;
   uitf_pkg::meta_type   s1_meta_ff;

   logic                 issue, credit_ok;
   logic [QL:0]          out_count, credit_sum;
   logic                 out_empty;
   logic [RW-1:0]        out_push_data, out_head;
   uitf_pkg::meta_type   head_meta;

   logic                 ram_we;
   logic [AW-1:0]        ram_waddr;
   logic [DW-1:0]        ram_wdata, ram_rdata;

   assign {op_we, op_re, op_addr, op_wdata, op_meta} = op_data;

   assign credit_sum = out_count + (QL + 1)'(s1_valid_ff);
   assign credit_ok  = credit_sum < (QL + 1)'(1 << QL);
   assign issue      = !clr_busy_ff && !op_empty && credit_ok;
   assign op_pop     = issue;

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == LAST) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
         s1_valid_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         s1_re_ff   <= op_re;
         s1_meta_ff <= op_meta;
      end
   end

   assign ram_we    = clr_busy_ff | (issue & op_we);
   assign ram_waddr = clr_busy_ff ? clr_addr_ff : op_addr;
   assign ram_wdata = clr_busy_ff ? '0 : op_wdata;

   uitf_ram #(
      .WIDTH (DW),
      .DEPTH (BUF_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (op_addr),
      .rdata (ram_rdata)
   );

   assign out_push_data = {s1_meta_ff, s1_re_ff ? ram_rdata : {DW{1'b0}}};

   uitf_fifo #(
      .WIDTH      (RW),
      .DEPTH_LOG2 (QL)
   ) u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (s1_valid_ff),
      .push_data (out_push_data),
      .pop       (rsp_pop && !out_empty),
      .pop_data  (out_head),
      .empty     (out_empty),
      .full      (),
      .count     (out_count)
   );

   assign {head_meta, rsp_read_byte} = out_head;
   assign rsp_frame_done   = head_meta.frame_done;
   assign rsp_frame_length = head_meta.frame_length;
   assign rsp_timer_active = head_meta.timer_active;
   assign rsp_empty        = out_empty;
   assign clearing         = clr_busy_ff;

endmodule

FILE: hdl/uart_idle_timeout_frame_receiver.sv
// Idle-line UART frame receiver: received bytes, timer ticks and host requests enter as
// transactions on a queue-style port and each produces exactly one result. One transaction
// is taken per clock cycle while full is low; a result passes through the op queue, the
// registered read of the frame buffer ram and the result fifo before it becomes visible.
// After reset the buffer ram is swept to zero, one entry per cycle over all BUF_DEPTH
// entries, and full stays high during that sweep; register writes are taken anyway.
// depends on uitf_pkg, uitf_front, uitf_fifo, uitf_back and the defines header
`include "uart_idle_timeout_frame_receiver_defines.svh"

module uart_idle_timeout_frame_receiver #(
   parameter int BUF_DEPTH = uitf_pkg::BUF_DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             push,
   output logic                             full,
   input  logic [2:0]                       req_type,
   input  logic [uitf_pkg::DATA_W-1:0]      req_rx_data,
   input  logic [uitf_pkg::IDX_W-1:0]       req_read_index,
   output logic                             empty,
   input  logic                             pop,
   output logic                             rsp_frame_done,
   output logic [uitf_pkg::LEN_W-1:0]       rsp_frame_length,
   output logic [uitf_pkg::DATA_W-1:0]      rsp_read_byte,
   output logic                             rsp_timer_active,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [uitf_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [uitf_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [uitf_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                             pready
);

   localparam int OP_W = 2 + $clog2(BUF_DEPTH) + uitf_pkg::DATA_W
                         + $bits(uitf_pkg::meta_type);

   logic [uitf_pkg::COUNT_W-1:0] timeout_ff, timeout_in;
   uitf_pkg::reg_index_type      csr_index;
   logic                         csr_write;

   logic                         accept, clearing;
   logic                         mid_full, mid_empty, mid_pop;
   logic [OP_W-1:0]              front_op, mid_op;
   uitf_pkg::front_status_type   front_status;

   // configuration register
   assign pready    = 1'b1;
   assign csr_index = uitf_pkg::reg_index_type'(paddr[2]);
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      timeout_in = timeout_ff;
      if (csr_write && csr_index == uitf_pkg::REG_IDLE_TIMEOUT) begin
         timeout_in = pwdata[uitf_pkg::COUNT_W-1:0];
      end
      prdata = '0;
      if (csr_index == uitf_pkg::REG_IDLE_TIMEOUT) begin
         prdata = {{(uitf_pkg::CSR_DATA_W - uitf_pkg::COUNT_W){1'b0}}, timeout_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= uitf_pkg::TIMEOUT_RESET;
      end else begin
         timeout_ff <= timeout_in;
      end
   end

   assign full   = mid_full | clearing;
   assign accept = push && !full;

   uitf_front #(
      .BUF_DEPTH (BUF_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req_type   (req_type),
      .rx_data    (req_rx_data),
      .read_index (req_read_index),
      .timeout    (timeout_ff),
      .op_data    (front_op),
      .status     (front_status)
   );

   uitf_fifo #(
      .WIDTH      (OP_W),
      .DEPTH_LOG2 (uitf_pkg::QUEUE_LOG2)
   ) u_op_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (front_op),
      .pop       (mid_pop),
      .pop_data  (mid_op),
      .empty     (mid_empty),
      .full      (mid_full),
      .count     ()
   );

   uitf_back #(
      .BUF_DEPTH (BUF_DEPTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .op_empty         (mid_empty),
      .op_data          (mid_op),
      .op_pop           (mid_pop),
      .clearing         (clearing),
      .rsp_pop          (pop),
      .rsp_empty        (empty),
      .rsp_frame_done   (rsp_frame_done),
      .rsp_frame_length (rsp_frame_length),
      .rsp_read_byte    (rsp_read_byte),
      .rsp_timer_active (rsp_timer_active)
   );

   // checks
   `UITF_ASSERT_IMPLY(a_clear_idle, clock, reset, clearing, full && empty, "transaction during clear sweep")
   `UITF_ASSERT_IMPLY(a_done_no_data, clock, reset, !empty && rsp_frame_done, rsp_read_byte == '0, "poll result carries data")
   `UITF_ASSERT_NEXT(a_poll_clears, clock, reset, accept && req_type == uitf_pkg::REQ_POLL, !front_status.done_pending, "poll left done flag set")
   `UITF_ASSERT_NEXT(a_byte_starts, clock, reset, accept && req_type == uitf_pkg::REQ_BYTE, front_status.running, "byte did not start idle counter")

endmodule
